// ===== hw/rtl/mm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg: shared types for the 4x4 fixed-point matrix multiplier
// Beat layouts of both channels, the control tag that travels with the
// multiply-accumulate pipeline, and the sequencer states.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int ELEM_W = 32;
    localparam int IDX_FIELD_W = 2;

    typedef struct packed {
        logic signed [ELEM_W-1:0]  element_value;
        logic                      matrix_select;
        logic [IDX_FIELD_W-1:0]    row_index;
        logic [IDX_FIELD_W-1:0]    column_index;
        logic                      start_multiply;
    } in_beat_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0]  product_value;
        logic [IDX_FIELD_W-1:0]    out_row;
        logic [IDX_FIELD_W-1:0]    out_column;
        logic                      last_entry;
        logic                      saturated;
    } out_beat_t;

    // Tag for one operand pair on its way through read, multiply and add.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mm_ctl_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_ISSUE,
        MM_WAIT
    } mm_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mm_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_store: operand matrix storage
// One write port and one read port with a registered read. A valid bit per
// entry makes entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module mm_store #(
    parameter int DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [DATA_WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic signed [DATA_WIDTH-1:0]       rd_data
);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? $signed(rd_data_reg) : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/mm_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_mac: multiply-accumulate unit
// Multiplies the operand pair read from the stores, accumulates one product
// entry exactly, then rescales it to the output format with saturation.
// ----------------------------------------------------------------------------
module mm_mac #(
    parameter int DIM = 4,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mm_pkg::mm_ctl_t               issue,
    input  wire logic signed [DATA_WIDTH-1:0]  left_data,
    input  wire logic signed [DATA_WIDTH-1:0]  right_data,
    input  wire logic                          done_clear,
    output logic                               done,
    output logic [DATA_WIDTH-1:0]              value,
    output logic                               sat
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W = PROD_W + $clog2(DIM) + 1;
    localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    mm_pkg::mm_ctl_t            s1_reg;
    mm_pkg::mm_ctl_t            s2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       done_reg;
    logic                       done_next;
    logic signed [ACC_W-1:0]    shifted;
    logic [ACC_W-DATA_WIDTH:0]  top_bits;
    logic                       fits;

    // The stores register their read data, so the tag passes through s1_reg
    // to line up with the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= done_next;
        end
    end

    assign prod_next = left_data * right_data;

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_reg.valid)
        begin
            if (s2_reg.first)
            begin
                acc_next = ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (done_clear)
        begin
            done_next = 1'b0;
        end
        if (s2_reg.valid && s2_reg.last)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // Arithmetic shift floors toward minus infinity; the entry fits when all
    // bits from the output sign bit upward agree.
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:DATA_WIDTH-1];
    assign fits     = (&top_bits) | (~|top_bits);

    assign done  = done_reg;
    assign sat   = ~fits;
    assign value = fits ? shifted[DATA_WIDTH-1:0] : (shifted[ACC_W-1] ? MIN_V : MAX_V);

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_multiply_4x4.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4: fixed-point DIM x DIM matrix multiplier
// Loads two operand matrices element by element and streams out their
// product in row-major order.
// ----------------------------------------------------------------------------
// A load beat is taken every cycle while the block is idle, and a beat with
// start_multiply set is stored before the product begins. The product entries
// are then computed one at a time by a single multiply-accumulate unit fed by
// the two operand memories, one operand pair per cycle: each entry issues DIM
// operand pairs, then waits while they pass the memory read, multiply and
// accumulate registers and while the output side stalls. No load beat is
// taken while the product runs. Entries are the exact sum of DIM products
// shifted right by FRAC_BITS (rounding toward minus infinity) and saturated
// to DATA_WIDTH bits. Both matrices read as zero after reset until written.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 #(
    parameter int DIM = 4,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire mm_pkg::in_beat_t  item_data,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output mm_pkg::out_beat_t      result_data
);

    localparam int IDX_W = $clog2(DIM);
    localparam int CELLS = DIM * DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
    localparam logic [3:0] DIM_L = 4'(DIM);

    mm_pkg::mm_state_t  state_reg;
    mm_pkg::mm_state_t  state_next;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   r_next;
    logic [IDX_W-1:0]   c_reg;
    logic [IDX_W-1:0]   c_next;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    mm_pkg::mm_ctl_t    issue;
    logic               load;

    logic               accept;
    logic               in_range;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  left_addr;
    logic [ADDR_W-1:0]  right_addr;
    logic signed [DATA_WIDTH-1:0] left_data;
    logic signed [DATA_WIDTH-1:0] right_data;

    logic                   mac_done;
    logic [DATA_WIDTH-1:0]  mac_value;
    logic                   mac_sat;

    logic                   result_valid_reg;
    logic                   result_valid_next;
    mm_pkg::out_beat_t      result_reg;
    mm_pkg::out_beat_t      result_next;
    logic                   out_free;

    assign item_stall = (state_reg != mm_pkg::MM_IDLE);
    assign accept     = item_valid && !item_stall;

    // Writes with a row or column outside the matrix are dropped.
    assign in_range = ({2'b00, item_data.row_index} < DIM_L)
                   && ({2'b00, item_data.column_index} < DIM_L);
    assign wr_addr  = ADDR_W'(item_data.row_index) * ADDR_W'(DIM)
                    + ADDR_W'(item_data.column_index);

    assign left_addr  = ADDR_W'(r_reg) * ADDR_W'(DIM) + ADDR_W'(k_reg);
    assign right_addr = ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(c_reg);

    mm_store #(
        .DEPTH      (CELLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && in_range && !item_data.matrix_select),
        .wr_addr (wr_addr),
        .wr_data (item_data.element_value[DATA_WIDTH-1:0]),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    mm_store #(
        .DEPTH      (CELLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && in_range && item_data.matrix_select),
        .wr_addr (wr_addr),
        .wr_data (item_data.element_value[DATA_WIDTH-1:0]),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    mm_mac #(
        .DIM        (DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .left_data  (left_data),
        .right_data (right_data),
        .done_clear (load),
        .done       (mac_done),
        .value      (mac_value),
        .sat        (mac_sat)
    );

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mm_pkg::MM_IDLE;
            r_reg            <= '0;
            c_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            r_reg            <= r_next;
            c_reg            <= c_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        issue      = '0;
        load       = 1'b0;
        case (state_reg)
            mm_pkg::MM_IDLE:
            begin
                if (accept && item_data.start_multiply)
                begin
                    state_next = mm_pkg::MM_ISSUE;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                end
            end
            mm_pkg::MM_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = (k_reg == LAST_IDX);
                if (k_reg == LAST_IDX)
                begin
                    k_next     = '0;
                    state_next = mm_pkg::MM_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mm_pkg::MM_WAIT:
            begin
                if (mac_done && out_free)
                begin
                    load = 1'b1;
                    if (r_reg == LAST_IDX && c_reg == LAST_IDX)
                    begin
                        state_next = mm_pkg::MM_IDLE;
                    end
                    else
                    begin
                        state_next = mm_pkg::MM_ISSUE;
                        if (c_reg == LAST_IDX)
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mm_pkg::MM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (load)
        begin
            result_valid_next         = 1'b1;
            result_next.product_value = mm_pkg::ELEM_W'($signed(mac_value));
            result_next.out_row       = mm_pkg::IDX_FIELD_W'(r_reg);
            result_next.out_column    = mm_pkg::IDX_FIELD_W'(c_reg);
            result_next.last_entry    = (r_reg == LAST_IDX) && (c_reg == LAST_IDX);
            result_next.saturated     = mac_sat;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_checker: port-level checks for the matrix multiplier
// Watches the load and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mm_checker #(
    parameter int DIM = 4,
    parameter int DATA_WIDTH = 32
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire mm_pkg::in_beat_t  item_data,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire mm_pkg::out_beat_t result_data
);

    localparam logic [mm_pkg::ELEM_W-1:0] MAX_V =
        mm_pkg::ELEM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic [mm_pkg::ELEM_W-1:0] MIN_V = ~MAX_V;
    localparam logic [mm_pkg::IDX_FIELD_W-1:0] LAST_IDX = mm_pkg::IDX_FIELD_W'(DIM - 1);

    // A result beat that is held back must stay put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // A taken start beat must be followed by a stall on the load channel.
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item_data.start_multiply |=> item_stall)
        else $error("load taken right after a start beat");

    // The final entry is always the bottom-right corner.
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.last_entry |->
            result_data.out_row == LAST_IDX && result_data.out_column == LAST_IDX)
        else $error("last entry flagged away from the final corner");

    // A clipped entry sits exactly at one end of the range.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.saturated |->
            result_data.product_value == MAX_V || result_data.product_value == MIN_V)
        else $error("saturated entry not at a range limit");

endmodule

bind matrix_multiply_4x4 mm_checker #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH)
) u_mm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
`default_nettype wire
